@@ sv/bdq_pkg.sv @@
// Shared types and codes for the bounded deque unit.
// No dependencies; used by bdq_ring_store and bounded_deque_with_queries_unit.

package bdq_pkg;

   // width of one stored entry
   localparam int DATA_W = 32;

   // operation codes carried on the request tuser
   typedef enum logic [2:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_CLEAR      = 3'd4,
      KIND_COUNT_GT   = 3'd5
   } kind_type;

   // result status codes carried on the response tuser
   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   // strobes from the sequencer to the ring store
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

@@ sv/bdq_ring_store.sv @@
// Ring store of the deque: one write port, one read port with registered data.
// Depends on bdq_pkg (DATA_W, mem_ctl_type).

module bdq_ring_store #(
   parameter int DEPTH = 64
) (
   input  logic                           clock,
   input  bdq_pkg::mem_ctl_type           ctl,
   input  logic [$clog2(DEPTH)-1:0]       wr_addr,
   input  logic [bdq_pkg::DATA_W-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0]       rd_addr,
   output logic [bdq_pkg::DATA_W-1:0]     rd_data
);

   logic [bdq_pkg::DATA_W-1:0] mem [DEPTH];
   logic [bdq_pkg::DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/bounded_deque_with_queries_unit.sv @@
// Top level of the bounded deque unit: operation sequencer and response register.
// Depends on bdq_pkg and bdq_ring_store.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  req     | in        | value[31:0], threshold[31:0]                | kind
//  rsp     | out       | length, last_value, last_valid, greater_cnt | status
//
// Push, pop, clear and unused kinds pass through the execute, back-entry read and
// fetch steps from accept to accept; the result is registered in the fetch step. A
// count query on a nonempty store first walks it (one ring-store read and one shared compare per entry).
// The ring store has one read port; the back entry is fetched after every op.
// Reset (synchronous) empties the deque; stored entries are not cleared.
// A stalled response holds the sequencer in its fetch step; a new request is
// accepted while a finished response still waits on rsp_tready.

module bounded_deque_with_queries_unit #(
   parameter int DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // value, threshold
   input  logic [63:0]            req_tdata,
   // kind
   input  logic [2:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // length, last_value, last_valid, greater_count, zero fill
   output logic [((2*$clog2(DEPTH+1)+bdq_pkg::DATA_W+1+7)/8)*8-1:0] rsp_tdata,
   // status
   output logic [1:0]             rsp_tuser
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH+1);
   localparam int DW    = bdq_pkg::DATA_W;
   localparam int RSP_W = ((2*CW+DW+1+7)/8)*8;
   localparam int PAD_W = RSP_W - (2*CW+DW+1);

   localparam logic [AW:0]   DEPTH_S = (AW+1)'(DEPTH);
   localparam logic [AW-1:0] LAST_IX = AW'(DEPTH-1);
   localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WALK,
      ST_DRAIN,
      ST_LAST,
      ST_FETCH
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic                 pend_ff, pend_in;
   logic [CW-1:0]        greater_ff, greater_in;
   logic [1:0]           status_ff, status_in;
   logic [2:0]           kind_ff, kind_in;
   logic [DW-1:0]        value_ff, value_in;
   logic [DW-1:0]        thr_ff, thr_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        rsp_len_ff, rsp_len_in;
   logic [DW-1:0]        rsp_last_ff, rsp_last_in;
   logic                 rsp_lvalid_ff, rsp_lvalid_in;
   logic [CW-1:0]        rsp_gcnt_ff, rsp_gcnt_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;

   // shared ring adder
   logic [AW-1:0]        ring_off;
   logic [AW:0]          ring_sum;
   logic [AW-1:0]        ring_pos;
   logic [AW-1:0]        head_dec;
   logic [CW-1:0]        last_off;

   bdq_pkg::mem_ctl_type mem_ctl;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic [DW-1:0]        rd_data;
   logic                 req_fire;
   logic                 rsp_free;
   logic                 is_full;
   logic                 is_empty;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign is_full  = (count_ff == FULL_C);
   assign is_empty = (count_ff == '0);
   assign last_off = count_ff - CW'(1);
   assign head_dec = (head_ff == '0) ? LAST_IX : head_ff - AW'(1);

   // offset into the ring, chosen by the current step
   always_comb begin
      ring_off = '0;
      unique case (state_ff)
         ST_EXEC: begin
            if (kind_ff == bdq_pkg::KIND_POP_FRONT) begin
               ring_off = AW'(1);
            end else begin
               ring_off = count_ff[AW-1:0];
            end
         end
         ST_WALK:  ring_off = idx_ff;
         ST_LAST:  ring_off = last_off[AW-1:0];
         default:  ring_off = '0;
      endcase
   end

   assign ring_sum = {1'b0, head_ff} + {1'b0, ring_off};
   assign ring_pos = (ring_sum >= DEPTH_S) ? AW'(ring_sum - DEPTH_S) : ring_sum[AW-1:0];

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = 1'b0;
      greater_in    = greater_ff;
      status_in     = status_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      thr_in        = thr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_len_in    = rsp_len_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_lvalid_in = rsp_lvalid_ff;
      rsp_gcnt_in   = rsp_gcnt_ff;
      rsp_status_in = rsp_status_ff;
      mem_ctl       = '0;
      wr_addr       = ring_pos;
      rd_addr       = ring_pos;

      // compare the word read in the previous cycle
      if (pend_ff && ($signed(rd_data) > $signed(thr_ff))) begin
         greater_in = greater_ff + CW'(1);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = req_tuser;
               value_in = req_tdata[DW-1:0];
               thr_in   = req_tdata[2*DW-1:DW];
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            status_in  = bdq_pkg::STATUS_DONE;
            greater_in = '0;
            idx_in     = '0;
            state_in   = ST_LAST;
            unique case (kind_ff)
               bdq_pkg::KIND_PUSH_FRONT: begin
                  if (is_full) begin
                     status_in = bdq_pkg::STATUS_FULL;
                  end else begin
                     head_in       = head_dec;
                     wr_addr       = head_dec;
                     mem_ctl.wr_en = 1'b1;
                     count_in      = count_ff + CW'(1);
                  end
               end
               bdq_pkg::KIND_PUSH_BACK: begin
                  if (is_full) begin
                     status_in = bdq_pkg::STATUS_FULL;
                  end else begin
                     mem_ctl.wr_en = 1'b1;
                     count_in      = count_ff + CW'(1);
                  end
               end
               bdq_pkg::KIND_POP_FRONT: begin
                  if (is_empty) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else begin
                     head_in  = ring_pos;
                     count_in = last_off;
                  end
               end
               bdq_pkg::KIND_POP_BACK: begin
                  if (is_empty) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = last_off;
                  end
               end
               bdq_pkg::KIND_CLEAR: begin
                  if (is_empty) begin
                     status_in = bdq_pkg::STATUS_EMPTY;
                  end else begin
                     count_in = '0;
                  end
               end
               bdq_pkg::KIND_COUNT_GT: begin
                  if (!is_empty) begin
                     state_in = ST_WALK;
                  end
               end
               default: begin
               end
            endcase
         end

         // one read per entry, front to back
         ST_WALK: begin
            mem_ctl.rd_en = 1'b1;
            pend_in       = 1'b1;
            idx_in        = idx_ff + AW'(1);
            if ({{(CW-AW){1'b0}}, idx_ff} == last_off) begin
               state_in = ST_DRAIN;
            end
         end

         ST_DRAIN: begin
            state_in = ST_LAST;
         end

         // fetch the back entry
         ST_LAST: begin
            mem_ctl.rd_en = 1'b1;
            state_in      = ST_FETCH;
         end

         // load the response once the output register is free
         ST_FETCH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_len_in    = count_ff;
               rsp_lvalid_in = !is_empty;
               rsp_last_in   = is_empty ? '0 : rd_data;
               rsp_gcnt_in   = greater_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      greater_ff    <= greater_in;
      status_ff     <= status_in;
      kind_ff       <= kind_in;
      value_ff      <= value_in;
      thr_ff        <= thr_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_lvalid_ff <= rsp_lvalid_in;
      rsp_gcnt_ff   <= rsp_gcnt_in;
      rsp_status_ff <= rsp_status_in;
   end

   bdq_ring_store #(
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_gcnt_ff, rsp_lvalid_ff, rsp_last_ff, rsp_len_ff};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   // the entry count never passes the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_C)
      else $error("entry count above depth");

   // last_valid in a response agrees with its length
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_lvalid_ff == (rsp_len_ff != '0)))
      else $error("last_valid does not match length");

   // a count can never exceed the length it was taken over
   a_greater_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_gcnt_ff <= rsp_len_ff))
      else $error("greater count above length");

   // an accepted word keeps the sequencer busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("ready right after accept");
`endif

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the bounded deque unit: directed table, then phased random traffic.
// Depends on bdq_pkg and the RTL top level bounded_deque_with_queries_unit.

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH  = 64;
   localparam int LEN_W  = $clog2(DEPTH + 1);
   localparam int RSP_W  = ((2 * LEN_W + bdq_pkg::DATA_W + 1 + 7) / 8) * 8;
   localparam int NUM_DIRECTED = 21;
   localparam int NUM_RANDOM   = 830;
   localparam int DRAIN_CYCLES = 100;

   // kinds the block accepts but does nothing with
   localparam logic [2:0] KIND_SPARE_6 = 3'd6;
   localparam logic [2:0] KIND_SPARE_7 = 3'd7;

   localparam logic signed [31:0] MAX_VAL = 32'sh7fffffff;
   localparam logic signed [31:0] MIN_VAL = 32'sh80000000;

   // response tdata layout, low bit up
   localparam int LEN_LSB   = 0;
   localparam int LAST_LSB  = LEN_LSB + LEN_W;
   localparam int VALID_BIT = LAST_LSB + bdq_pkg::DATA_W;
   localparam int GT_LSB    = VALID_BIT + 1;

   typedef struct {
      logic [6:0]          length;
      logic signed [31:0]  last_value;
      logic                last_valid;
      logic [6:0]          greater_count;
      bdq_pkg::status_type status;
   } deque_result_type;

   typedef struct {
      logic [2:0]         kind;
      logic signed [31:0] value;
      logic signed [31:0] threshold;
      bit                 typed;
      deque_result_type   want;
   } op_row_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // value, threshold
   logic [63:0]      req_tdata = '0;
   // kind
   logic [2:0]       req_tuser = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // length, last_value, last_valid, greater_count, zero fill
   logic [RSP_W-1:0] rsp_tdata;
   // status
   logic [1:0]       rsp_tuser;

   bounded_deque_with_queries_unit #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // shadow copy of the deque
   logic signed [31:0] shadow_ring [DEPTH];
   logic [5:0]         shadow_head;
   logic [6:0]         shadow_count;

   deque_result_type pending_results [$];
   int  failures     = 0;
   int  words_sent   = 0;
   int  words_seen   = 0;
   int  full_drops   = 0;
   int  empty_skips  = 0;
   int  count_hits   = 0;
   bit  req_quiet    = 1'b0;
   bit  rsp_quiet    = 1'b0;

   // rows with typed=1 carry a hand-written expectation
   op_row_type directed_ops [NUM_DIRECTED] = '{
      '{bdq_pkg::KIND_POP_FRONT,  32'sd0, 32'sd0, 1'b1,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_EMPTY}},
      '{bdq_pkg::KIND_POP_BACK,   32'sd5, 32'sd0, 1'b1,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_EMPTY}},
      '{bdq_pkg::KIND_CLEAR,      32'sd0, 32'sd0, 1'b1,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_EMPTY}},
      '{bdq_pkg::KIND_COUNT_GT,   32'sd0, MIN_VAL, 1'b1,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}},
      '{KIND_SPARE_6,             MAX_VAL, MAX_VAL, 1'b1,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_PUSH_BACK,  MAX_VAL, 32'sd0, 1'b1,
        '{7'd1, MAX_VAL, 1'b1, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_PUSH_FRONT, MIN_VAL, 32'sd0, 1'b1,
        '{7'd2, MAX_VAL, 1'b1, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_COUNT_GT,   32'sd0, MIN_VAL, 1'b1,
        '{7'd2, MAX_VAL, 1'b1, 7'd1, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_COUNT_GT,   32'sd0, MAX_VAL, 1'b1,
        '{7'd2, MAX_VAL, 1'b1, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_COUNT_GT,   32'sd0, 32'sh7ffffffe, 1'b1,
        '{7'd2, MAX_VAL, 1'b1, 7'd1, bdq_pkg::STATUS_DONE}},
      '{KIND_SPARE_7,             32'sd1, 32'sd1, 1'b1,
        '{7'd2, MAX_VAL, 1'b1, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_POP_BACK,   32'sd0, 32'sd0, 1'b1,
        '{7'd1, MIN_VAL, 1'b1, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_PUSH_BACK,  32'sd0, 32'sd0, 1'b0,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_PUSH_FRONT, -32'sd1, 32'sd0, 1'b0,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_COUNT_GT,   32'sd0, -32'sd1, 1'b0,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_POP_FRONT,  32'sd0, 32'sd0, 1'b0,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_CLEAR,      32'sd0, 32'sd0, 1'b1,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_POP_FRONT,  32'sd0, 32'sd0, 1'b1,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_EMPTY}},
      '{bdq_pkg::KIND_PUSH_FRONT, 32'sd12345, 32'sd0, 1'b0,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_POP_FRONT,  32'sd0, 32'sd0, 1'b0,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}},
      '{bdq_pkg::KIND_COUNT_GT,   32'sd0, MIN_VAL, 1'b1,
        '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE}}
   };

   // shadow deque: apply one operation and return the result it should produce
   function automatic deque_result_type apply_deque_op(logic [2:0] kind,
                                                       logic signed [31:0] value,
                                                       logic signed [31:0] threshold);
      deque_result_type r;
      logic [5:0]       idx;
      r = '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE};
      case (kind)
         bdq_pkg::KIND_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               r.status = bdq_pkg::STATUS_FULL;
            end else begin
               shadow_head = shadow_head - 6'd1;
               shadow_ring[shadow_head] = value;
               shadow_count++;
            end
         end
         bdq_pkg::KIND_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               r.status = bdq_pkg::STATUS_FULL;
            end else begin
               idx = shadow_head + shadow_count[5:0];
               shadow_ring[idx] = value;
               shadow_count++;
            end
         end
         bdq_pkg::KIND_POP_FRONT: begin
            if (shadow_count == 0) begin
               r.status = bdq_pkg::STATUS_EMPTY;
            end else begin
               shadow_head = shadow_head + 6'd1;
               shadow_count--;
            end
         end
         bdq_pkg::KIND_POP_BACK: begin
            if (shadow_count == 0) r.status = bdq_pkg::STATUS_EMPTY;
            else shadow_count--;
         end
         bdq_pkg::KIND_CLEAR: begin
            if (shadow_count == 0) r.status = bdq_pkg::STATUS_EMPTY;
            else shadow_count = 7'd0;
         end
         bdq_pkg::KIND_COUNT_GT: begin
            for (int i = 0; i < shadow_count; i++) begin
               idx = shadow_head + 6'(i);
               if (shadow_ring[idx] > threshold) r.greater_count++;
            end
         end
         default: ;
      endcase
      r.length = shadow_count;
      if (shadow_count != 0) begin
         idx = shadow_head + shadow_count[5:0] - 6'd1;
         r.last_valid = 1'b1;
         r.last_value = shadow_ring[idx];
      end
      return r;
   endfunction

   // idle cycles before the next word; quiet stretches have none
   function automatic int draw_gap(bit quiet);
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   // operation mix per phase: fill, churn near full, drain, anything
   function automatic logic [2:0] pick_kind(int phase);
      int r;
      r = $urandom_range(0, 99);
      case (phase)
         0: begin
            if (r < 45) return bdq_pkg::KIND_PUSH_BACK;
            if (r < 85) return bdq_pkg::KIND_PUSH_FRONT;
            if (r < 92) return bdq_pkg::KIND_COUNT_GT;
            if (r < 96) return bdq_pkg::KIND_POP_FRONT;
            return bdq_pkg::KIND_POP_BACK;
         end
         1: begin
            if (r < 30) return bdq_pkg::KIND_PUSH_BACK;
            if (r < 50) return bdq_pkg::KIND_PUSH_FRONT;
            if (r < 65) return bdq_pkg::KIND_POP_FRONT;
            if (r < 80) return bdq_pkg::KIND_POP_BACK;
            if (r < 96) return bdq_pkg::KIND_COUNT_GT;
            return (r < 98) ? KIND_SPARE_6 : KIND_SPARE_7;
         end
         2: begin
            if (r < 35) return bdq_pkg::KIND_POP_FRONT;
            if (r < 70) return bdq_pkg::KIND_POP_BACK;
            if (r < 82) return bdq_pkg::KIND_COUNT_GT;
            if (r < 91) return bdq_pkg::KIND_PUSH_BACK;
            return bdq_pkg::KIND_PUSH_FRONT;
         end
         default: begin
            if (r < 5) return bdq_pkg::KIND_CLEAR;
            if (r < 8) return (r < 7) ? KIND_SPARE_6 : KIND_SPARE_7;
            return 3'($urandom_range(0, 5));
         end
      endcase
   endfunction

   // extremes, values clustered near zero, or anything
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return MIN_VAL;
      if (r == 1) return MAX_VAL;
      if (r < 5) return 32'($signed($urandom_range(0, 16)) - 8);
      return $urandom;
   endfunction

   // offer one request word, then predict its result at acceptance
   task automatic send_word(logic [2:0] kind, logic signed [31:0] value,
                            logic signed [31:0] threshold, bit typed,
                            deque_result_type want);
      int               gap;
      deque_result_type predicted;
      if ($urandom_range(0, 39) == 0) req_quiet = ~req_quiet;
      gap = draw_gap(req_quiet);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {threshold, value};
      req_tuser  <= kind;
      do @(posedge clock); while (!req_tready);
      predicted = apply_deque_op(kind, value, threshold);
      pending_results.push_back(typed ? want : predicted);
      words_sent++;
      if (predicted.status == bdq_pkg::STATUS_FULL) full_drops++;
      if (predicted.status == bdq_pkg::STATUS_EMPTY) empty_skips++;
      if (predicted.greater_count != 0) count_hits++;
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // stimulus and end of run
   initial begin
      deque_result_type blank;
      blank = '{7'd0, 32'sd0, 1'b0, 7'd0, bdq_pkg::STATUS_DONE};
      shadow_head  = 6'd0;
      shadow_count = 7'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_ops[i])
         send_word(directed_ops[i].kind, directed_ops[i].value, directed_ops[i].threshold,
                   directed_ops[i].typed, directed_ops[i].want);

      for (int i = 0; i < NUM_RANDOM; i++)
         send_word(pick_kind((i / 100) % 4), pick_value(), pick_value(), 1'b0, blank);
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d results never arrived", pending_results.size());
         failures++;
      end

      $display("Sent %0d words (%0d directed), checked %0d results.", words_sent,
               NUM_DIRECTED, words_seen);
      $display("Full-store drops %0d, empty pops/clears %0d, nonzero counts %0d.",
               full_drops, empty_skips, count_hits);
      if (failures == 0)
         $display("PASS bounded_deque_with_queries_unit");
      else
         $display("FAIL bounded_deque_with_queries_unit");
      $finish;
   end

   // result side: random back-pressure and field-by-field check
   initial begin
      int               gap;
      deque_result_type want;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_quiet = ~rsp_quiet;
         gap = draw_gap(rsp_quiet);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         words_seen++;
         if (pending_results.size() == 0) begin
            $error("result word with no expectation pending");
            failures++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[LEN_LSB +: LEN_W] !== want.length) begin
               $error("length: expected %0d, got %0d", want.length,
                      rsp_tdata[LEN_LSB +: LEN_W]);
               failures++;
            end
            if (rsp_tdata[LAST_LSB +: bdq_pkg::DATA_W] !== want.last_value) begin
               $error("last_value: expected %0d, got %0d", want.last_value,
                      $signed(rsp_tdata[LAST_LSB +: bdq_pkg::DATA_W]));
               failures++;
            end
            if (rsp_tdata[VALID_BIT] !== want.last_valid) begin
               $error("last_valid: expected %0d, got %0d", want.last_valid,
                      rsp_tdata[VALID_BIT]);
               failures++;
            end
            if (rsp_tdata[GT_LSB +: LEN_W] !== want.greater_count) begin
               $error("greater_count: expected %0d, got %0d", want.greater_count,
                      rsp_tdata[GT_LSB +: LEN_W]);
               failures++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               failures++;
            end
         end
      end
   end

   // hard stop well past the slowest legal run
   initial begin
      #1_000_000;
      $display("FAIL bounded_deque_with_queries_unit");
      $finish;
   end

endmodule
